// ===== sv/bpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg: shared constants for the buddy page allocator
// Holds default parameters and the operation and status codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int DefPageBits    = 12;
  localparam int DefRegionPages = 4096;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

endpackage
`default_nettype wire

// ===== sv/bpa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram: generic single-port RAM
// One access per cycle; read data registered, old data returned on a write.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== sv/bpa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl: sequencer for the buddy page allocator
// Steps a one-hot state machine through init, alloc and free, issuing
// memory commands to the datapath.
// ----------------------------------------------------------------------------
module bpa_ctrl
  import bpa_pkg::*;
#(
  parameter int PageBits = DefPageBits
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   op,
  input  wire logic [PageBits-1:0]          page_index,
  input  wire logic [PageBits:0]            request_pages,
  input  wire logic [PageBits:0]            region_pages,
  // output channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        status,
  output logic [PageBits-1:0]               block_index,
  // memory ports (to datapath)
  output logic                              ps_we,
  output logic [PageBits-1:0]               ps_addr,
  output logic [$clog2(PageBits + 2)-1:0]   ps_wdata,
  input  wire logic [$clog2(PageBits + 2)-1:0] ps_rdata,
  output logic                              nx_we,
  output logic [PageBits-1:0]               nx_addr,
  output logic [PageBits:0]                 nx_wdata,
  input  wire logic [PageBits:0]            nx_rdata,
  output logic                              pv_we,
  output logic [PageBits-1:0]               pv_addr,
  output logic [PageBits:0]                 pv_wdata,
  input  wire logic [PageBits:0]            pv_rdata
);
  localparam int Orders = PageBits + 1;
  localparam int OW = $clog2(Orders + 1);
  localparam int StW = $clog2(PageBits + 2);
  localparam logic [PageBits:0] Nil = {1'b1, {PageBits{1'b0}}};

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_CLR    = 17'b00000000000000010,
    S_ILAY   = 17'b00000000000000100,
    S_PUSH   = 17'b00000000000001000,
    S_PUSH2  = 17'b00000000000010000,
    S_ASRCH  = 17'b00000000000100000,
    S_RMRD   = 17'b00000000001000000,
    S_RMWT   = 17'b00000000010000000,
    S_RMNX   = 17'b00000000100000000,
    S_RMPV   = 17'b00000001000000000,
    S_ASPLIT = 17'b00000010000000000,
    S_FRD    = 17'b00000100000000000,
    S_FWT    = 17'b00001000000000000,
    S_FCHK   = 17'b00010000000000000,
    S_BRD    = 17'b00100000000000000,
    S_BWT    = 17'b01000000000000000,
    S_DONE   = 17'b10000000000000000
  } state_t;

  // return point after list push
  typedef enum logic [2:0] {
    R_INIT  = 3'b001,
    R_SPLIT = 3'b010,
    R_END   = 3'b100
  } ret_t;

  state_t state;
  ret_t   ret;
  logic [PageBits:0]   head [Orders];
  logic [PageBits:0]   active;
  logic [OW-1:0]       ord;     // current order
  logic [OW-1:0]       want;
  logic [PageBits-1:0] blk;     // block being allocated or freed
  logic [PageBits-1:0] rblk;    // block to unlink
  logic [PageBits-1:0] pblk;    // block to push
  logic [OW-1:0]       pord;    // order for push
  logic                merging; // unlink belongs to a free merge
  logic [PageBits:0]   rmn, rmp;
  logic [PageBits:0]   at;
  logic [PageBits-1:0] clr;
  logic [1:0]          res_st;
  logic [PageBits-1:0] res_blk;
  logic                busy_out;
  logic [OW-1:0]       req_ord;
  logic [PageBits-1:0] buddy;
  logic [PageBits+1:0] ord_size;
  logic [PageBits+1:0] bud_end;
  logic [PageBits+1:0] v_end;
  logic                bad_free;

  // order of request, Orders when too large
  always_comb begin
    logic [PageBits:0] r;
    r = (request_pages == '0) ? {{PageBits{1'b0}}, 1'b1} : request_pages;
    req_ord = OW'(Orders);
    for (int i = Orders - 1; i >= 0; i--) begin
      if (r <= (PageBits + 1)'(1 << i)) begin
        req_ord = OW'(i);
      end
    end
  end

  assign ord_size = (PageBits + 2)'(1) << ord;
  assign buddy    = blk ^ (PageBits'(1) << ord);
  assign bud_end  = {2'b00, buddy} + ord_size;
  assign v_end    = {2'b00, blk} + ord_size;
  assign bad_free = ((blk & PageBits'(ord_size - 1'b1)) != '0)
                    || (v_end > {1'b0, active}) || (ps_rdata != '0);

  assign in_ready    = (state == S_IDLE) && !busy_out;
  assign out_valid   = busy_out;
  assign status      = res_st;
  assign block_index = res_blk;

  // memory command decode
  always_comb begin
    ps_we = 1'b0; ps_addr = blk; ps_wdata = '0;
    nx_we = 1'b0; nx_addr = blk; nx_wdata = '0;
    pv_we = 1'b0; pv_addr = blk; pv_wdata = '0;
    unique case (state)
      S_CLR: begin
        ps_we = 1'b1; ps_addr = clr;
      end
      S_PUSH: begin
        ps_we = 1'b1; ps_addr = pblk; ps_wdata = StW'(pord) + StW'(1);
        nx_we = 1'b1; nx_addr = pblk; nx_wdata = head[pord];
        pv_we = 1'b1; pv_addr = pblk; pv_wdata = Nil;
      end
      S_PUSH2: begin
        pv_we = !head[pord][PageBits];
        pv_addr = head[pord][PageBits-1:0]; pv_wdata = {1'b0, pblk};
      end
      S_RMRD: begin
        nx_addr = rblk; pv_addr = rblk;
      end
      S_RMNX: begin
        ps_we = 1'b1; ps_addr = rblk;
        pv_we = !rmn[PageBits]; pv_addr = rmn[PageBits-1:0]; pv_wdata = rmp;
      end
      S_RMPV: begin
        nx_we = !rmp[PageBits]; nx_addr = rmp[PageBits-1:0]; nx_wdata = rmn;
      end
      S_BRD: begin
        ps_addr = buddy; nx_addr = buddy; pv_addr = buddy;
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      busy_out <= 1'b0;
      active   <= '0;
      ret      <= R_END;
      merging  <= 1'b0;
      res_st   <= ST_OK;
      res_blk  <= '0;
      for (int i = 0; i < Orders; i++) head[i] <= Nil;
    end else begin
      // result handshake
      if (state == S_DONE) busy_out <= 1'b1;
      else if (busy_out && out_ready) busy_out <= 1'b0;

      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          res_st  <= ST_OK;
          res_blk <= '0;
          blk     <= page_index;
          want    <= req_ord;
          clr     <= '0;
          at      <= '0;
          unique case (op)
            OP_INIT: begin
              active <= region_pages;
              ord    <= OW'(PageBits);
              for (int i = 0; i < Orders; i++) head[i] <= Nil;
              state  <= S_CLR;
            end
            OP_ALLOC: begin
              ord <= req_ord;
              if (req_ord == OW'(Orders)) begin
                res_st <= ST_NOSPACE;
                state  <= S_DONE;
              end else begin
                state <= S_ASRCH;
              end
            end
            OP_FREE: begin
              ord <= req_ord;
              if (req_ord == OW'(Orders)) begin
                res_st <= ST_BADFREE;
                state  <= S_DONE;
              end else begin
                state <= S_FRD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        // clear page status, then lay out the region
        S_CLR: begin
          clr <= clr + 1'b1;
          if (&clr) state <= S_ILAY;
        end
        S_ILAY: if (active[ord]) begin
          pblk  <= at[PageBits-1:0];
          pord  <= ord;
          ret   <= R_INIT;
          at    <= at + ((PageBits + 1)'(1) << ord);
          state <= S_PUSH;
        end else if (ord == '0) begin
          state <= S_DONE;
        end else begin
          ord <= ord - 1'b1;
        end
        // list push: write the block, then link the old head back
        S_PUSH: state <= S_PUSH2;
        S_PUSH2: begin
          head[pord] <= {1'b0, pblk};
          unique case (ret)
            R_INIT: begin
              if (pord == '0) begin
                state <= S_DONE;
              end else begin
                ord   <= pord - 1'b1;
                state <= S_ILAY;
              end
            end
            R_SPLIT: state <= S_ASPLIT;
            default: state <= S_DONE;
          endcase
        end
        // alloc: find the smallest non-empty order at or above the wanted one
        S_ASRCH: if (ord == OW'(Orders)) begin
          res_st <= ST_NOSPACE;
          state  <= S_DONE;
        end else if (!head[ord][PageBits]) begin
          blk     <= head[ord][PageBits-1:0];
          rblk    <= head[ord][PageBits-1:0];
          res_blk <= head[ord][PageBits-1:0];
          merging <= 1'b0;
          state   <= S_RMRD;
        end else begin
          ord <= ord + 1'b1;
        end
        // list unlink
        S_RMRD: state <= S_RMWT;
        S_RMWT: begin
          rmn   <= nx_rdata;
          rmp   <= pv_rdata;
          state <= S_RMNX;
        end
        S_RMNX: state <= S_RMPV;
        S_RMPV: begin
          if (rmp[PageBits] && head[ord] == {1'b0, rblk}) head[ord] <= rmn;
          if (merging) begin
            // merged block keeps the lower page of the pair
            blk   <= blk & ~(PageBits'(1) << ord);
            ord   <= ord + 1'b1;
            state <= S_FCHK;
          end else begin
            state <= S_ASPLIT;
          end
        end
        // alloc: hand back the upper half of each split
        S_ASPLIT: if (ord == want) begin
          state <= S_DONE;
        end else begin
          pblk  <= blk + (PageBits'(1) << (ord - 1'b1));
          pord  <= ord - 1'b1;
          ord   <= ord - 1'b1;
          ret   <= R_SPLIT;
          state <= S_PUSH;
        end
        // free: alignment, range and status check
        S_FRD: state <= S_FWT;
        S_FWT: if (bad_free) begin
          res_st <= ST_BADFREE;
          state  <= S_DONE;
        end else begin
          state <= S_FCHK;
        end
        // free: merge while the buddy is free at this order
        S_FCHK: if (ord == OW'(PageBits) || bud_end > {1'b0, active}) begin
          pblk  <= blk;
          pord  <= ord;
          ret   <= R_END;
          state <= S_PUSH;
        end else begin
          state <= S_BRD;
        end
        S_BRD: state <= S_BWT;
        S_BWT: if (ps_rdata != StW'(ord) + StW'(1)) begin
          pblk  <= blk;
          pord  <= ord;
          ret   <= R_END;
          state <= S_PUSH;
        end else begin
          rmn     <= nx_rdata;
          rmp     <= pv_rdata;
          rblk    <= buddy;
          merging <= 1'b1;
          state   <= S_RMNX;
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/bpa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_dp: storage datapath for the buddy page allocator
// Page status and list link memories plus the region size register.
// ----------------------------------------------------------------------------
module bpa_dp
  import bpa_pkg::*;
#(
  parameter int PageBits = DefPageBits
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [PageBits:0]               cfg_data,
  output logic [PageBits:0]                    region_pages,
  input  wire logic                            ps_we,
  input  wire logic [PageBits-1:0]             ps_addr,
  input  wire logic [$clog2(PageBits + 2)-1:0] ps_wdata,
  output logic [$clog2(PageBits + 2)-1:0]      ps_rdata,
  input  wire logic                            nx_we,
  input  wire logic [PageBits-1:0]             nx_addr,
  input  wire logic [PageBits:0]               nx_wdata,
  output logic [PageBits:0]                    nx_rdata,
  input  wire logic                            pv_we,
  input  wire logic [PageBits-1:0]             pv_addr,
  input  wire logic [PageBits:0]               pv_wdata,
  output logic [PageBits:0]                    pv_rdata
);
  localparam int Depth = 1 << PageBits;
  localparam int StW = $clog2(PageBits + 2);
  localparam int ResetPages = (DefRegionPages > Depth) ? Depth : DefRegionPages;
  logic [PageBits:0] reg_q;

  // region size register, clipped to the store size
  always_ff @(posedge clk) begin
    if (rst) reg_q <= (PageBits + 1)'(ResetPages);
    else if (cfg_we) reg_q <= cfg_data;
  end
  assign region_pages = (reg_q > (PageBits + 1)'(Depth)) ? (PageBits + 1)'(Depth) : reg_q;

  bpa_ram #(.Width(StW), .Depth(Depth)) u_ps (
    .clk(clk), .we(ps_we), .addr(ps_addr), .wdata(ps_wdata), .rdata(ps_rdata));
  bpa_ram #(.Width(PageBits + 1), .Depth(Depth)) u_nx (
    .clk(clk), .we(nx_we), .addr(nx_addr), .wdata(nx_wdata), .rdata(nx_rdata));
  bpa_ram #(.Width(PageBits + 1), .Depth(Depth)) u_pv (
    .clk(clk), .we(pv_we), .addr(pv_addr), .wdata(pv_wdata), .rdata(pv_rdata));
endmodule
`default_nettype wire

// ===== sv/buddy_page_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator: buddy allocator over a region of pages
// Alloc splits a larger free block as needed, status NOSPACE when no block
// fits; free merges with free buddies; init clears every page status, then
// lays out the region as free blocks, one per set bit of the region size.
// Throughput: one item at a time; next item accepted once the result leaves.
// Reset: nothing free until an init; region size register resets to 4096, clipped to the store size.
// ----------------------------------------------------------------------------
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int PageBits = DefPageBits
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [PageBits:0]   cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          op,
  input  wire logic [PageBits-1:0] page_index,
  input  wire logic [PageBits:0]   request_pages,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               status,
  output logic [PageBits-1:0]      block_index
);
  localparam int StW = $clog2(PageBits + 2);

  logic [PageBits:0]   region_pages;
  logic                ps_we, nx_we, pv_we;
  logic [PageBits-1:0] ps_addr, nx_addr, pv_addr;
  logic [StW-1:0]      ps_wdata, ps_rdata;
  logic [PageBits:0]   nx_wdata, nx_rdata, pv_wdata, pv_rdata;

  bpa_ctrl #(.PageBits(PageBits)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .page_index(page_index), .request_pages(request_pages),
    .region_pages(region_pages), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .block_index(block_index),
    .ps_we(ps_we), .ps_addr(ps_addr), .ps_wdata(ps_wdata), .ps_rdata(ps_rdata),
    .nx_we(nx_we), .nx_addr(nx_addr), .nx_wdata(nx_wdata), .nx_rdata(nx_rdata),
    .pv_we(pv_we), .pv_addr(pv_addr), .pv_wdata(pv_wdata), .pv_rdata(pv_rdata));

  bpa_dp #(.PageBits(PageBits)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .region_pages(region_pages),
    .ps_we(ps_we), .ps_addr(ps_addr), .ps_wdata(ps_wdata), .ps_rdata(ps_rdata),
    .nx_we(nx_we), .nx_addr(nx_addr), .nx_wdata(nx_wdata), .nx_rdata(nx_rdata),
    .pv_we(pv_we), .pv_addr(pv_addr), .pv_wdata(pv_wdata), .pv_rdata(pv_rdata));
endmodule
`default_nettype wire
